// ----- src/lrmb_pkg.sv -----
package lrmb_pkg;

   localparam int SLOT_W      = 6;
   localparam int VALUE_W     = 24;
   localparam int DUR_W       = 16;
   localparam int TICKS_W     = 16;
   localparam int RATE_W      = 18;
   localparam int LIMIT_W     = 16;
   localparam int CSR_DATA_W  = 18;
   localparam int CSR_INDEX_W = 1;
   localparam int CLOCK_W     = 32;
   localparam int SLOPE_W     = 40;
   localparam int SLOPE_FRAC  = 15;
   localparam int PROD_W      = DUR_W + RATE_W;
   localparam int SAMPLES_W   = 25;
   localparam int DIV_NUM_W   = VALUE_W + SLOPE_FRAC;
   localparam int DIV_DEN_W   = SAMPLES_W;

   localparam logic [RATE_W-1:0]  RATE_RESET  = 18'd48000;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd128;
   localparam logic [9:0]         MS_PER_S    = 10'd1000;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_TICK   = 1'b1
   } command_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SAMPLE_RATE     = 1'b0,
      CSR_IMMEDIATE_LIMIT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] end_value;
      logic [CLOCK_W-1:0]        end_sample;
      logic signed [SLOPE_W-1:0] slope;
   } slot_entry_type;

endpackage

// ----- src/linear_ramp_modulator_bank_core.sv -----
// Insert: an out-of-range slot is dropped without going busy; an immediate ramp gives its result
// from the check state; a stored ramp runs the check, sample-count, slope-setup, 39-step slope
// division (skipped without a slope) and write states. Tick: busy while the slot memory is walked
// one entry per cycle; each active slot's result passes stages s0 to s3, one per cycle at most.
// Results leave on a one-cycle strobe; the receiver cannot stall them.
// Synchronous reset clears the sample clock and all active flags and restores the registers.
module linear_ramp_modulator_bank_core import lrmb_pkg::*; #(
   parameter int SLOT_COUNT = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_command,
   input  logic [SLOT_W-1:0]         req_target_slot,
   input  logic signed [VALUE_W-1:0] req_start_value,
   input  logic signed [VALUE_W-1:0] req_end_value,
   input  logic [DUR_W-1:0]          req_duration_ms,
   input  logic [TICKS_W-1:0]        req_tick_samples,
   output logic                      rsp_strobe,
   output logic [SLOT_W-1:0]         rsp_out_slot,
   output logic signed [VALUE_W-1:0] rsp_out_value,
   output logic                      rsp_last_of_tick,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_write_data
);

   localparam int ADDR_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int PIPE_LAT  = 4;
   localparam int WALK_W    = $clog2(SLOT_COUNT + PIPE_LAT + 1);
   localparam int MUL_SPLIT = 20;
   localparam int HI_W      = DIV_NUM_W - MUL_SPLIT;
   localparam int REM_W     = CLOCK_W - 1;
   localparam int PRODUCT_W = DIV_NUM_W + REM_W;
   localparam int OFF_W     = PRODUCT_W - SLOPE_FRAC;
   localparam int SUM_W     = OFF_W + 2;

   // The sample count is (prod / 8) / 125, taken by a reciprocal multiply that is exact
   // for every 31-bit dividend.
   localparam int EIGHTH_W     = PROD_W - 3;
   localparam int RECIP_W      = 32;
   localparam int RECIP_SHIFT  = 38;
   localparam int RECIP_PROD_W = EIGHTH_W + RECIP_W;
   localparam logic [RECIP_W-1:0] MS_RECIP = 32'd2199023256;

   localparam logic [WALK_W-1:0] WALK_SLOTS = WALK_W'(SLOT_COUNT);
   localparam logic [WALK_W-1:0] WALK_LAST  = WALK_W'(SLOT_COUNT + PIPE_LAT - 1);
   localparam logic [SLOT_W:0]   SLOT_LIMIT = (SLOT_W + 1)'(SLOT_COUNT);
   localparam logic [5:0]        DIV_LAST   = 6'(DIV_NUM_W - 1);
   localparam logic signed [SUM_W-1:0] SUM_MIN = -(SUM_W'(64'sd8388608));
   localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(64'sd8388607);
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 24'sh800000;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 24'sh7FFFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV_SAMPLES,
      ST_SETUP_SLOPE,
      ST_DIV_SLOPE,
      ST_WRITE,
      ST_WALK
   } state_type;

   state_type state_ff;
   logic [RATE_W-1:0]         rate_ff;
   logic [LIMIT_W-1:0]        limit_ff;
   logic [CLOCK_W-1:0]        clock_ff;
   logic [SLOT_COUNT-1:0]     active_ff;

   logic [SLOT_W-1:0]         slot_ff;
   logic signed [VALUE_W-1:0] start_ff;
   logic signed [VALUE_W-1:0] end_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic [SAMPLES_W-1:0]      samples_ff;
   logic [DIV_DEN_W-1:0]      div_rem_ff;
   logic [DIV_NUM_W-1:0]      div_quo_ff;
   logic [DIV_DEN_W-1:0]      div_den_ff;
   logic [5:0]                div_cnt_ff;
   logic [CLOCK_W-1:0]        end_sample_ff;
   logic                      slope_neg_ff;
   logic signed [SLOPE_W-1:0] slope_ff;
   logic [WALK_W-1:0]         walk_ff;

   logic                      s0_valid_ff;
   logic [SLOT_W-1:0]         s0_slot_ff;
   logic                      s0_last_ff;
   logic                      s1_valid_ff;
   logic [SLOT_W-1:0]         s1_slot_ff;
   logic                      s1_last_ff;
   logic                      s1_done_ff;
   logic                      s1_neg_ff;
   logic signed [VALUE_W-1:0] s1_end_ff;
   logic [DIV_NUM_W-1:0]      s1_mag_ff;
   logic [REM_W-1:0]          s1_rem_ff;
   logic                      s2_valid_ff;
   logic [SLOT_W-1:0]         s2_slot_ff;
   logic                      s2_last_ff;
   logic                      s2_done_ff;
   logic                      s2_neg_ff;
   logic signed [VALUE_W-1:0] s2_end_ff;
   logic [MUL_SPLIT+REM_W-1:0] s2_lo_ff;
   logic [HI_W+REM_W-1:0]     s2_hi_ff;
   logic                      s3_valid_ff;
   logic [SLOT_W-1:0]         s3_slot_ff;
   logic                      s3_last_ff;
   logic                      s3_done_ff;
   logic                      s3_neg_ff;
   logic signed [VALUE_W-1:0] s3_end_ff;
   logic [OFF_W-1:0]          s3_off_ff;

   logic                      rsp_strobe_ff;
   logic [SLOT_W-1:0]         rsp_slot_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic                      rsp_last_ff;

   slot_entry_type            slot_mem [SLOT_COUNT];
   slot_entry_type            mem_rd_ff;
   slot_entry_type            mem_wdata;
   logic                      mem_we;
   logic [ADDR_W-1:0]         mem_waddr;
   logic [ADDR_W-1:0]         mem_raddr;

   logic                      accept;
   logic [DIV_DEN_W:0]        div_shift;
   logic [DIV_DEN_W:0]        div_diff;
   logic                      div_fit;
   logic [DIV_DEN_W-1:0]      div_rem_in;
   logic [DIV_NUM_W-1:0]      div_quo_in;
   logic [PROD_W-1:0]         limit_scaled;
   logic signed [VALUE_W:0]   delta;
   logic [VALUE_W:0]          delta_abs;
   logic [RECIP_PROD_W-1:0]   samples_mul;
   logic                      issue;
   logic                      issue_valid;
   logic                      later_active;
   logic [CLOCK_W-1:0]        s1_diff;
   logic                      s1_done;
   logic [SLOPE_W-1:0]        s1_abs;
   logic [PRODUCT_W-1:0]      s3_product;
   logic signed [SUM_W-1:0]   s4_end_ext;
   logic signed [SUM_W-1:0]   s4_off_ext;
   logic signed [SUM_W-1:0]   s4_sum;
   logic signed [VALUE_W-1:0] s4_value;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // One restoring step of the serial slope divider.
   assign div_shift  = {div_rem_ff, div_quo_ff[DIV_NUM_W-1]};
   assign div_diff   = div_shift - {1'b0, div_den_ff};
   assign div_fit    = (div_shift >= {1'b0, div_den_ff});
   assign div_rem_in = div_fit ? div_diff[DIV_DEN_W-1:0] : div_shift[DIV_DEN_W-1:0];
   assign div_quo_in = {div_quo_ff[DIV_NUM_W-2:0], div_fit};

   assign limit_scaled = PROD_W'(limit_ff) * PROD_W'(MS_PER_S);
   assign delta        = {end_ff[VALUE_W-1], end_ff} - {start_ff[VALUE_W-1], start_ff};
   assign delta_abs    = delta[VALUE_W] ? -delta : delta;
   assign samples_mul  = RECIP_PROD_W'(prod_ff[PROD_W-1:3]) * RECIP_PROD_W'(MS_RECIP);

   assign mem_we    = (state_ff == ST_WRITE);
   assign mem_waddr = slot_ff[ADDR_W-1:0];
   assign mem_wdata = '{end_value: end_ff, end_sample: end_sample_ff, slope: slope_ff};
   assign mem_raddr = walk_ff[ADDR_W-1:0];

   assign issue       = (state_ff == ST_WALK) && (walk_ff < WALK_SLOTS);
   assign issue_valid = issue && active_ff[mem_raddr];

   // A slot is the last of its tick when no higher slot is active.
   always_comb begin
      later_active = 1'b0;
      for (int j = 0; j < SLOT_COUNT; j++) begin
         if (active_ff[j] && (WALK_W'(j) > walk_ff)) begin
            later_active = 1'b1;
         end
      end
   end

   assign s1_diff = mem_rd_ff.end_sample - clock_ff;
   assign s1_done = s1_diff[CLOCK_W-1] || (s1_diff == '0);
   assign s1_abs  = mem_rd_ff.slope[SLOPE_W-1] ? -mem_rd_ff.slope : mem_rd_ff.slope;

   assign s3_product = {s2_hi_ff, {MUL_SPLIT{1'b0}}} + PRODUCT_W'(s2_lo_ff);

   assign s4_end_ext = {{(SUM_W - VALUE_W){s3_end_ff[VALUE_W-1]}}, s3_end_ff};
   assign s4_off_ext = $signed({2'b00, s3_off_ff});
   assign s4_sum     = s3_neg_ff ? (s4_end_ext + s4_off_ext) : (s4_end_ext - s4_off_ext);

   always_comb begin
      priority if (s3_done_ff) begin
         s4_value = s3_end_ff;
      end else if (s4_sum < SUM_MIN) begin
         s4_value = VALUE_MIN;
      end else if (s4_sum > SUM_MAX) begin
         s4_value = VALUE_MAX;
      end else begin
         s4_value = s4_sum[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      mem_rd_ff <= slot_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rate_ff       <= RATE_RESET;
         limit_ff      <= LIMIT_RESET;
         clock_ff      <= '0;
         active_ff     <= '0;
         walk_ff       <= '0;
         div_cnt_ff    <= '0;
         s0_valid_ff   <= 1'b0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index_type'(csr_index))
               CSR_SAMPLE_RATE: begin
                  rate_ff <= csr_write_data[RATE_W-1:0];
               end
               CSR_IMMEDIATE_LIMIT: begin
                  limit_ff <= csr_write_data[LIMIT_W-1:0];
               end
            endcase
         end

         // Value pipeline for the tick walk.
         s0_valid_ff <= issue_valid;
         s0_slot_ff  <= SLOT_W'(walk_ff);
         s0_last_ff  <= !later_active;

         s1_valid_ff <= s0_valid_ff;
         s1_slot_ff  <= s0_slot_ff;
         s1_last_ff  <= s0_last_ff;
         s1_done_ff  <= s1_done;
         s1_neg_ff   <= mem_rd_ff.slope[SLOPE_W-1];
         s1_end_ff   <= mem_rd_ff.end_value;
         s1_mag_ff   <= s1_abs[DIV_NUM_W-1:0];
         s1_rem_ff   <= s1_diff[REM_W-1:0];
         if (s0_valid_ff && s1_done) begin
            active_ff[s0_slot_ff[ADDR_W-1:0]] <= 1'b0;
         end

         s2_valid_ff <= s1_valid_ff;
         s2_slot_ff  <= s1_slot_ff;
         s2_last_ff  <= s1_last_ff;
         s2_done_ff  <= s1_done_ff;
         s2_neg_ff   <= s1_neg_ff;
         s2_end_ff   <= s1_end_ff;
         s2_lo_ff    <= (MUL_SPLIT + REM_W)'(s1_mag_ff[MUL_SPLIT-1:0])
                        * (MUL_SPLIT + REM_W)'(s1_rem_ff);
         s2_hi_ff    <= (HI_W + REM_W)'(s1_mag_ff[DIV_NUM_W-1:MUL_SPLIT])
                        * (HI_W + REM_W)'(s1_rem_ff);

         s3_valid_ff <= s2_valid_ff;
         s3_slot_ff  <= s2_slot_ff;
         s3_last_ff  <= s2_last_ff;
         s3_done_ff  <= s2_done_ff;
         s3_neg_ff   <= s2_neg_ff;
         s3_end_ff   <= s2_end_ff;
         s3_off_ff   <= s3_product[PRODUCT_W-1:SLOPE_FRAC];

         rsp_strobe_ff <= s3_valid_ff;
         rsp_slot_ff   <= s3_slot_ff;
         rsp_value_ff  <= s4_value;
         rsp_last_ff   <= s3_last_ff;

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_command == CMD_TICK) begin
                     clock_ff <= clock_ff + CLOCK_W'(req_tick_samples);
                     walk_ff  <= '0;
                     state_ff <= ST_WALK;
                  end else begin
                     slot_ff  <= req_target_slot;
                     start_ff <= req_start_value;
                     end_ff   <= req_end_value;
                     prod_ff  <= PROD_W'(req_duration_ms) * PROD_W'(rate_ff);
                     if ({1'b0, req_target_slot} < SLOT_LIMIT) begin
                        active_ff[req_target_slot[ADDR_W-1:0]] <= 1'b0;
                        state_ff <= ST_CHECK;
                     end
                  end
               end
            end
            ST_CHECK: begin
               if (prod_ff <= limit_scaled) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_slot_ff   <= slot_ff;
                  rsp_value_ff  <= end_ff;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= ST_IDLE;
               end else begin
                  state_ff <= ST_DIV_SAMPLES;
               end
            end
            ST_DIV_SAMPLES: begin
               samples_ff <= samples_mul[RECIP_SHIFT+SAMPLES_W-1:RECIP_SHIFT];
               state_ff   <= ST_SETUP_SLOPE;
            end
            ST_SETUP_SLOPE: begin
               if ((start_ff == end_ff) || (samples_ff == '0)) begin
                  slope_ff      <= '0;
                  end_sample_ff <= clock_ff;
                  state_ff      <= ST_WRITE;
               end else begin
                  end_sample_ff <= clock_ff + CLOCK_W'(samples_ff);
                  div_quo_ff    <= {delta_abs[VALUE_W-1:0], {SLOPE_FRAC{1'b0}}};
                  div_rem_ff    <= '0;
                  div_den_ff    <= samples_ff;
                  div_cnt_ff    <= '0;
                  slope_neg_ff  <= delta[VALUE_W];
                  state_ff      <= ST_DIV_SLOPE;
               end
            end
            ST_DIV_SLOPE: begin
               div_quo_ff <= div_quo_in;
               div_rem_ff <= div_rem_in;
               div_cnt_ff <= div_cnt_ff + 6'd1;
               if (div_cnt_ff == DIV_LAST) begin
                  slope_ff <= slope_neg_ff ? -$signed({1'b0, div_quo_in})
                                           : $signed({1'b0, div_quo_in});
                  state_ff <= ST_WRITE;
               end
            end
            ST_WRITE: begin
               active_ff[slot_ff[ADDR_W-1:0]] <= 1'b1;
               state_ff <= ST_IDLE;
            end
            ST_WALK: begin
               walk_ff <= walk_ff + WALK_W'(1);
               if (walk_ff == WALK_LAST) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_out_slot     = rsp_slot_ff;
   assign rsp_out_value    = rsp_value_ff;
   assign rsp_last_of_tick = rsp_last_ff;

endmodule

// ----- src/lrmb_checker.sv -----
module lrmb_checker import lrmb_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              req_command,
   input logic              rsp_strobe,
   input logic [SLOT_W-1:0] rsp_out_slot,
   input logic              rsp_last_of_tick
);

   // A tick always walks the slot memory, so the block must report busy.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_command == CMD_TICK) |=> busy)
      else $error("tick transfer did not make the block busy");

   // Nothing follows the final result of an item in the very next cycle.
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_of_tick |=> !rsp_strobe)
      else $error("result directly after the final result of an item");

   // A result that is not the last promises more work or another result.
   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_of_tick |=> rsp_strobe || busy)
      else $error("block went idle before the final result of a tick");

   // Back-to-back results come from neighboring slots in ascending order.
   a_slot_order: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(rsp_strobe) |-> rsp_out_slot == SLOT_W'($past(rsp_out_slot) + 1'b1))
      else $error("consecutive results out of slot order");

endmodule

bind linear_ramp_modulator_bank_core lrmb_checker u_lrmb_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_command      (req_command),
   .rsp_strobe       (rsp_strobe),
   .rsp_out_slot     (rsp_out_slot),
   .rsp_last_of_tick (rsp_last_of_tick)
);

// ----- verif/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lrmb_pkg::*;

   localparam int SLOT_COUNT     = 64;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 100;
   localparam logic signed [VALUE_W-1:0] Q_LOW  = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] Q_HIGH = {1'b0, {(VALUE_W-1){1'b1}}};

   typedef struct {
      command_type               cmd;
      logic [SLOT_W-1:0]         slot;
      logic signed [VALUE_W-1:0] from_value;
      logic signed [VALUE_W-1:0] to_value;
      logic [DUR_W-1:0]          dur_ms;
      logic [TICKS_W-1:0]        ticks;
   } ramp_request_type;

   typedef struct packed {
      logic [SLOT_W-1:0]         slot;
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } param_write_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   command_type               req_command = CMD_INSERT;
   logic [SLOT_W-1:0]         req_target_slot = '0;
   logic signed [VALUE_W-1:0] req_start_value = '0;
   logic signed [VALUE_W-1:0] req_end_value = '0;
   logic [DUR_W-1:0]          req_duration_ms = '0;
   logic [TICKS_W-1:0]        req_tick_samples = '0;
   logic                      rsp_strobe;
   logic [SLOT_W-1:0]         rsp_out_slot;
   logic signed [VALUE_W-1:0] rsp_out_value;
   logic                      rsp_last_of_tick;
   logic                      csr_write_enable = 1'b0;
   csr_index_type             csr_index = CSR_SAMPLE_RATE;
   logic [CSR_DATA_W-1:0]     csr_write_data = '0;

   // Mirror of the ramp bank.
   int unsigned               model_rate = 48000;
   int unsigned               model_limit = 128;
   logic [CLOCK_W-1:0]        model_clock = '0;
   bit                        ramp_live [SLOT_COUNT];
   logic signed [VALUE_W-1:0] ramp_target [SLOT_COUNT];
   logic [CLOCK_W-1:0]        ramp_finish [SLOT_COUNT];
   longint                    ramp_slope [SLOT_COUNT];

   ramp_request_type pending_cmds[$];
   ramp_request_type next_cmd;
   param_write_type  param_writes[$];
   param_write_type  expected_write;
   int               send_gap_pct = 32;
   int               error_count = 0;
   int               quiet_cycles = 0;

   linear_ramp_modulator_bank_core #(.SLOT_COUNT(SLOT_COUNT)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_target_slot  (req_target_slot),
      .req_start_value  (req_start_value),
      .req_end_value    (req_end_value),
      .req_duration_ms  (req_duration_ms),
      .req_tick_samples (req_tick_samples),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_slot     (rsp_out_slot),
      .rsp_out_value    (rsp_out_value),
      .rsp_last_of_tick (rsp_last_of_tick),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Works out the parameter writes that one accepted command causes.
   function automatic void predict_ramp_command(command_type cmd, logic [SLOT_W-1:0] slot,
         logic signed [VALUE_W-1:0] from_value, logic signed [VALUE_W-1:0] to_value,
         logic [DUR_W-1:0] dur_ms, logic [TICKS_W-1:0] ticks);
      longint unsigned prod;
      longint unsigned threshold;
      longint unsigned samples;
      longint unsigned mag;
      longint unsigned offset;
      longint          delta;
      longint          remaining;
      longint          level;
      logic [CLOCK_W-1:0] gap;
      param_write_type burst[$];
      param_write_type pw;
      if (cmd == CMD_INSERT) begin
         if (slot >= SLOT_COUNT) return;
         prod = 64'(dur_ms);
         prod = prod * 64'(model_rate);
         threshold = 64'(model_limit);
         threshold = threshold * 1000;
         ramp_live[slot] = 1'b0;
         if (prod <= threshold) begin
            pw.slot = slot;
            pw.value = to_value;
            pw.last = 1'b1;
            param_writes = {param_writes, pw};
            return;
         end
         samples = prod / 1000;
         ramp_live[slot] = 1'b1;
         ramp_target[slot] = to_value;
         if (from_value == to_value || samples == 0) begin
            ramp_slope[slot] = 0;
            ramp_finish[slot] = model_clock;
         end else begin
            delta = 64'(to_value);
            delta = delta - 64'(from_value);
            mag = (delta < 0) ? -delta : delta;
            mag = mag << SLOPE_FRAC;
            ramp_slope[slot] = mag / samples;
            if (delta < 0) ramp_slope[slot] = -ramp_slope[slot];
            ramp_finish[slot] = model_clock + samples[CLOCK_W-1:0];
         end
         return;
      end
      model_clock = model_clock + CLOCK_W'(ticks);
      for (int s = 0; s < SLOT_COUNT; s++) begin
         if (ramp_live[s]) begin
            gap = ramp_finish[s] - model_clock;
            remaining = 64'($signed(gap));
            level = 64'(ramp_target[s]);
            if (remaining <= 0) begin
               ramp_live[s] = 1'b0;
            end else begin
               mag = (ramp_slope[s] < 0) ? -ramp_slope[s] : ramp_slope[s];
               offset = mag * remaining;
               offset = offset >> SLOPE_FRAC;
               if (ramp_slope[s] < 0) level = level + offset;
               else level = level - offset;
               if (level < Q_LOW) level = Q_LOW;
               if (level > Q_HIGH) level = Q_HIGH;
            end
            pw.slot = s[SLOT_W-1:0];
            pw.value = level[VALUE_W-1:0];
            pw.last = 1'b0;
            burst = {burst, pw};
         end
      end
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      param_writes = {param_writes, burst};
   endfunction

   function automatic ramp_request_type noise_fields();
      ramp_request_type r;
      r.cmd = command_type'($urandom_range(1));
      r.slot = SLOT_W'($urandom);
      r.from_value = VALUE_W'($urandom);
      r.to_value = VALUE_W'($urandom);
      r.dur_ms = DUR_W'($urandom);
      r.ticks = TICKS_W'($urandom);
      return r;
   endfunction

   function automatic void queue_insert(logic [SLOT_W-1:0] slot,
         logic signed [VALUE_W-1:0] from_value, logic signed [VALUE_W-1:0] to_value,
         logic [DUR_W-1:0] dur_ms);
      ramp_request_type r;
      r = noise_fields();
      r.cmd = CMD_INSERT;
      r.slot = slot;
      r.from_value = from_value;
      r.to_value = to_value;
      r.dur_ms = dur_ms;
      pending_cmds = {pending_cmds, r};
   endfunction

   function automatic void queue_tick(logic [TICKS_W-1:0] ticks);
      ramp_request_type r;
      r = noise_fields();
      r.cmd = CMD_TICK;
      r.ticks = ticks;
      pending_cmds = {pending_cmds, r};
   endfunction

   // Durations are aimed at the immediate boundary of the current settings and at
   // ramps a few ticks long, so that stored ramps run through to retirement.
   function automatic void queue_random_command();
      ramp_request_type r;
      longint unsigned  boundary_ms;
      longint unsigned  span_ms;
      longint unsigned  dur;
      int               pick;
      r = noise_fields();
      pick = $urandom_range(99);
      if (pick < 55) begin
         r.cmd = CMD_TICK;
         pick = $urandom_range(99);
         if (pick < 10) r.ticks = '0;
         else if (pick < 65) r.ticks = TICKS_W'($urandom_range(1500));
         else if (pick < 90) r.ticks = TICKS_W'($urandom_range(8000));
      end else begin
         r.cmd = CMD_INSERT;
         boundary_ms = 65535;
         span_ms = 0;
         if (model_rate != 0) begin
            boundary_ms = 64'(model_limit);
            boundary_ms = boundary_ms * 1000 / model_rate;
            span_ms = 6000000 / model_rate;
         end
         if (boundary_ms > 65535) boundary_ms = 65535;
         pick = $urandom_range(99);
         dur = 64'(r.dur_ms);
         if (pick < 20) dur = 64'($urandom_range(32'(boundary_ms)));
         else if (pick < 30) dur = boundary_ms + 64'($urandom_range(1));
         else if (pick < 85) dur = boundary_ms + 1 + 64'($urandom_range(32'(span_ms)));
         if (dur > 65535) dur = 65535;
         r.dur_ms = dur[DUR_W-1:0];
         pick = $urandom_range(99);
         if (pick < 10) r.to_value = r.from_value;
         else if (pick < 14) begin
            r.from_value = Q_LOW;
            r.to_value = Q_HIGH;
         end else if (pick < 18) begin
            r.from_value = Q_HIGH;
            r.to_value = Q_LOW;
         end
         if ($urandom_range(99) < 30) r.slot = SLOT_W'($urandom_range(7));
      end
      pending_cmds = {pending_cmds, r};
   endfunction

   task automatic settle();
      while (pending_cmds.size() != 0 || start) @(posedge clock);
      while (param_writes.size() != 0) @(posedge clock);
      // Stored inserts and empty ticks give nothing back; let them finish.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      if (idx == CSR_SAMPLE_RATE) model_rate = 32'(data[RATE_W-1:0]);
      else model_limit = 32'(data[LIMIT_W-1:0]);
   endtask

   task automatic run_phase(logic [CSR_DATA_W-1:0] rate, logic [CSR_DATA_W-1:0] limit,
         int gap_pct, int count);
      settle();
      write_reg(CSR_SAMPLE_RATE, rate);
      write_reg(CSR_IMMEDIATE_LIMIT, limit);
      csr_write_enable <= 1'b0;
      send_gap_pct = gap_pct;
      repeat (count) queue_random_command();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (pending_cmds.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            next_cmd = pending_cmds.pop_front();
            start <= 1'b1;
            req_command <= next_cmd.cmd;
            req_target_slot <= next_cmd.slot;
            req_start_value <= next_cmd.from_value;
            req_end_value <= next_cmd.to_value;
            req_duration_ms <= next_cmd.dur_ms;
            req_tick_samples <= next_cmd.ticks;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Results are checked before a command accepted on the same edge is predicted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            if (param_writes.size() == 0) begin
               $error("unexpected parameter write: slot %0d value %0d", rsp_out_slot,
                  rsp_out_value);
               error_count++;
            end else begin
               expected_write = param_writes.pop_front();
               if (rsp_out_slot !== expected_write.slot) begin
                  $error("out_slot: expected %0d, got %0d", expected_write.slot, rsp_out_slot);
                  error_count++;
               end
               if (rsp_out_value !== expected_write.value) begin
                  $error("out_value: expected %0d, got %0d", expected_write.value,
                     rsp_out_value);
                  error_count++;
               end
               if (rsp_last_of_tick !== expected_write.last) begin
                  $error("last_of_tick: expected %0b, got %0b", expected_write.last,
                     rsp_last_of_tick);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            predict_ramp_command(req_command, req_target_slot, req_start_value, req_end_value,
               req_duration_ms, req_tick_samples);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: 48 samples per ms, a ramp of 2 ms or less is immediate.
      queue_tick(16'd0);
      queue_insert(6'd0, Q_LOW, Q_HIGH, 16'd0);
      queue_insert(6'd63, Q_HIGH, Q_LOW, 16'd2);
      queue_insert(6'd63, 24'sh123456, 24'sh123456, 16'd3);
      queue_insert(6'd0, Q_LOW, Q_HIGH, 16'hFFFF);
      queue_insert(6'd1, Q_HIGH, Q_LOW, 16'd10);
      queue_insert(6'd2, 24'sd0, 24'sd1000, 16'd5);
      queue_tick(16'd0);
      queue_tick(16'd240);
      queue_tick(16'hFFFF);
      // An immediate insert drops the long ramp held in the same slot.
      queue_insert(6'd0, 24'sd0, 24'sd0, 16'd1);
      queue_tick(16'd1);
      queue_insert(6'd10, 24'sd100, -24'sd100, 16'd3);
      queue_insert(6'd11, -24'sd5, 24'sd7, 16'd50);
      queue_tick(16'd143);
      queue_tick(16'd1);
      queue_insert(6'd11, 24'sd5, 24'sd5, 16'd4000);
      queue_tick(16'd0);
      queue_insert(6'd20, Q_LOW, Q_HIGH, 16'd3);
      queue_insert(6'd20, Q_HIGH, Q_LOW, 16'd7);
      queue_tick(16'd100);
      queue_tick(16'hFFFF);

      // The limit write carries stray upper bits that the register drops.
      run_phase(18'd48000, 18'h30080, 32, 70);
      run_phase(18'd8000, 18'd1, 32, 50);
      run_phase(18'd192000, 18'd65535, 45, 55);
      run_phase(18'h3FFFF, 18'd500, 45, 40);
      // A limit of zero with a slow rate gives stored ramps of zero samples.
      run_phase(18'd700, 18'd0, 0, 45);
      // A rate of zero makes every insert immediate.
      run_phase(18'd0, 18'd200, 0, 20);
      run_phase(18'd44100, 18'd64, 0, 30);
      settle();

      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end
endmodule

// ----- sim.f -----
src/lrmb_pkg.sv
src/linear_ramp_modulator_bank_core.sv
src/lrmb_checker.sv
verif/tb.sv
